// ----- src/pnau_pkg.sv -----
package pnau_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [15:0] ADDR_P1_CTRL = 16'h4000;
  localparam logic [15:0] ADDR_P1_LO   = 16'h4002;
  localparam logic [15:0] ADDR_P1_HI   = 16'h4003;
  localparam logic [15:0] ADDR_P2_CTRL = 16'h4004;
  localparam logic [15:0] ADDR_P2_LO   = 16'h4006;
  localparam logic [15:0] ADDR_P2_HI   = 16'h4007;
  localparam logic [15:0] ADDR_TRI_HI  = 16'h400B;
  localparam logic [15:0] ADDR_N_CTRL  = 16'h400C;
  localparam logic [15:0] ADDR_N_PER   = 16'h400E;
  localparam logic [15:0] ADDR_N_LEN   = 16'h400F;
  localparam logic [15:0] ADDR_DMC_LVL = 16'h4011;
  localparam logic [15:0] ADDR_STATUS  = 16'h4015;
  localparam logic [15:0] ADDR_FRAME   = 16'h4017;

  localparam logic [20:0] CPU_CLOCK  = 21'd1789773;
  localparam logic [19:0] DIV_UNIT   = 20'd705600;
  localparam logic [13:0] PULSE_WGT  = 14'd8411;
  localparam logic [12:0] NOISE_WGT  = 13'd5525;
  localparam logic [8:0]  DMC_WGT    = 9'd439;

  function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] idx);
    logic [7:0] row;
    case (duty)
      2'd0:    row = 8'b0000_0010;
      2'd1:    row = 8'b0000_0110;
      2'd2:    row = 8'b0001_1110;
      default: row = 8'b1111_1001;
    endcase
    return row[idx];
  endfunction

  function automatic logic [11:0] noise_period_lut(input logic [3:0] code);
    case (code)
      4'd0:    return 12'd4;
      4'd1:    return 12'd8;
      4'd2:    return 12'd16;
      4'd3:    return 12'd32;
      4'd4:    return 12'd64;
      4'd5:    return 12'd96;
      4'd6:    return 12'd128;
      4'd7:    return 12'd160;
      4'd8:    return 12'd202;
      4'd9:    return 12'd254;
      4'd10:   return 12'd380;
      4'd11:   return 12'd508;
      4'd12:   return 12'd762;
      4'd13:   return 12'd1016;
      4'd14:   return 12'd2034;
      default: return 12'd4068;
    endcase
  endfunction

  typedef struct packed {
    logic start;
    logic [10:0] period;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/pnau_step_div.sv -----
module pnau_step_div #(
  parameter int PHASE_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pnau_pkg::div_req_t      req_i,
  output pnau_pkg::div_stat_t     stat_o,
  output logic [PHASE_BITS-1:0]   quot_o
);
  import pnau_pkg::*;

  localparam int CW = $clog2(PHASE_BITS + 1);

  // divisor up to 705600*2048 < 2^31
  logic [31:0] den_q, den_d;
  logic [32:0] rem_q, rem_d;
  logic [PHASE_BITS-1:0] quot_q, quot_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [32:0] shifted;
  logic [33:0] diff;

  always_comb begin
    shifted = {rem_q[31:0], 1'b0};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    den_d   = den_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      den_d  = 32'(DIV_UNIT) * (32'(req_i.period) + 32'd1);
      rem_d  = 33'(CPU_CLOCK);
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[33]) begin
        rem_d  = diff[32:0];
        quot_d = {quot_q[PHASE_BITS-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[PHASE_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(PHASE_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

// ----- src/pulse_noise_audio_unit.sv -----
// channel   | group  | tdata (low bit up)                           | tuser
// input     | s_axis | action[1:0] address[17:2] write_data[25:18] | -
// output    | m_axis | read_data[7:0] sample_value[26:8]           | result_kind
// A write or a read is done on accept; a tick steps the pulse channels in turn, skipping
// the division for each silent pulse channel, on the one restoring divider shared by both
// pulse channels.
// Reset is asynchronous, active low, and clears all channel state.
// Input is not ready while an item is at work or a result waits on m_axis.
module pulse_noise_audio_unit #(
  parameter int PHASE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // action, address, write_data
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // read_data, sample_value
  output logic        m_axis_tuser    // result_kind
);
  import pnau_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_MIX  = 3'd3;

  logic [2:0] st_q, st_d;
  logic       ch_q, ch_d;

  logic [1:0]  duty_q [2];
  logic        pfix_q [2];
  logic [3:0]  pvol_q [2];
  logic [3:0]  penv_q [2];
  logic [10:0] pper_q [2];
  logic [4:0]  plen_q [2];
  logic [PHASE_BITS-1:0] phase_q [2];
  logic        nfix_q, nshort_q;
  logic [3:0]  nvol_q, nenv_q;
  logic [11:0] nper_q;
  logic [15:0] ntim_q;
  logic [4:0]  nlen_q, tlen_q, en_q;
  logic [14:0] lfsr_q;
  logic [6:0]  dmc_q;
  logic        frame_q;
  logic [4:0]  psum_q;
  logic [3:0]  nout_q;
  logic        okind_q;
  logic [7:0]  ordata_q;
  logic [18:0] osample_q;
  logic        ovalid_q;

  logic [1:0]  act;
  logic [15:0] addr;
  logic [7:0]  wdat;
  logic        in_acc, out_acc;
  div_req_t    dreq;
  div_stat_t   dstat;
  logic [PHASE_BITS-1:0] dquot;
  logic        pact;
  logic [3:0]  plvl;
  logic [15:0] ntim_dec;
  logic        nfb;
  logic [14:0] lfsr_nx;
  logic [3:0]  nlvl;

  assign act    = s_axis_tdata[1:0];
  assign addr   = s_axis_tdata[17:2];
  assign wdat   = s_axis_tdata[25:18];
  assign s_axis_tready = (st_q == ST_IDLE) && !ovalid_q;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign pact = (plen_q[ch_q] != 5'd0) && (pper_q[ch_q] >= 11'd8);
  assign plvl = pfix_q[ch_q] ? pvol_q[ch_q] : penv_q[ch_q];
  assign dreq.start  = (st_q == ST_DIV) && pact;
  assign dreq.period = pper_q[ch_q];

  pnau_step_div #(.PHASE_BITS(PHASE_BITS)) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .stat_o(dstat),
    .quot_o(dquot)
  );

  assign ntim_dec = ntim_q - 16'd1;
  assign nfb      = lfsr_q[0] ^ (nshort_q ? lfsr_q[6] : lfsr_q[1]);
  assign lfsr_nx  = (ntim_dec == 16'd0) ? {nfb, lfsr_q[14:1]} : lfsr_q;
  assign nlvl     = nfix_q ? nvol_q : nenv_q;

  always_comb begin
    st_d = st_q;
    ch_d = ch_q;
    case (st_q)
      ST_IDLE: if (in_acc && act == ACT_TICK) begin
        st_d = ST_DIV;
        ch_d = 1'b0;
      end
      ST_DIV: st_d = pact ? ST_WAIT : (ch_q ? ST_MIX : ST_DIV);
      ST_WAIT: if (dstat.done) begin
        st_d = ch_q ? ST_MIX : ST_DIV;
      end
      ST_MIX: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
    if ((st_q == ST_DIV && !pact) || (st_q == ST_WAIT && dstat.done)) begin
      ch_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ch_q <= 1'b0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        duty_q[i] <= '0; pfix_q[i] <= '0; pvol_q[i] <= '0; penv_q[i] <= '0;
        pper_q[i] <= '0; plen_q[i] <= '0; phase_q[i] <= '0;
      end
      nfix_q <= 1'b0; nshort_q <= 1'b0; nvol_q <= '0; nenv_q <= '0;
      nper_q <= '0; ntim_q <= '0; nlen_q <= '0; tlen_q <= '0; en_q <= '0;
      lfsr_q <= 15'd1; dmc_q <= '0; frame_q <= 1'b0;
      psum_q <= '0; nout_q <= '0;
    end else begin
      st_q <= st_d;
      ch_q <= ch_d;
      if (out_acc) ovalid_q <= 1'b0;
      if (in_acc) begin
        case (act)
          ACT_WRITE: begin
            case (addr)
              ADDR_P1_CTRL, ADDR_P2_CTRL: begin
                duty_q[addr[2]] <= wdat[7:6];
                pfix_q[addr[2]] <= wdat[4];
                pvol_q[addr[2]] <= wdat[3:0];
              end
              ADDR_P1_LO, ADDR_P2_LO: pper_q[addr[2]][7:0] <= wdat;
              ADDR_P1_HI, ADDR_P2_HI: begin
                pper_q[addr[2]][10:8] <= wdat[2:0];
                plen_q[addr[2]] <= wdat[7:3];
                penv_q[addr[2]] <= 4'd15;
              end
              ADDR_TRI_HI: tlen_q <= wdat[7:3];
              ADDR_N_CTRL: begin
                nfix_q <= wdat[4];
                nvol_q <= wdat[3:0];
              end
              ADDR_N_PER: begin
                nshort_q <= wdat[7];
                nper_q <= noise_period_lut(wdat[3:0]);
              end
              ADDR_N_LEN: begin
                nlen_q <= wdat[7:3];
                nenv_q <= 4'd15;
              end
              ADDR_DMC_LVL: dmc_q <= wdat[6:0];
              ADDR_STATUS: begin
                en_q <= wdat[4:0];
                if (!wdat[0]) plen_q[0] <= '0;
                if (!wdat[1]) plen_q[1] <= '0;
                if (!wdat[2]) tlen_q <= '0;
                if (!wdat[3]) nlen_q <= '0;
              end
              ADDR_FRAME: frame_q <= wdat[6];
              default: ;
            endcase
          end
          ACT_READ: begin
            ovalid_q <= 1'b1;
            if (addr == ADDR_STATUS) frame_q <= 1'b0;
          end
          ACT_TICK: begin
            psum_q <= '0;
            nout_q <= '0;
            if (nlen_q != 5'd0) begin
              ntim_q <= (ntim_dec == 16'd0) ? 16'(nper_q) : ntim_dec;
              lfsr_q <= lfsr_nx;
              nout_q <= lfsr_nx[0] ? nlvl : 4'd0;
            end
          end
          default: ;
        endcase
      end
      if (st_q == ST_DIV && pact) begin
        psum_q <= psum_q + (duty_bit(duty_q[ch_q], phase_q[ch_q][PHASE_BITS-1 -: 3]) ?
                  5'(plvl) : 5'd0);
      end
      if (st_q == ST_WAIT && dstat.done) begin
        phase_q[ch_q] <= phase_q[ch_q] + dquot;
      end
      if (st_q == ST_MIX) ovalid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && act == ACT_READ) begin
      okind_q   <= 1'b0;
      osample_q <= '0;
      ordata_q  <= (addr == ADDR_STATUS) ?
                   {1'b0, frame_q, 2'b00, nlen_q != 5'd0, tlen_q != 5'd0,
                    plen_q[1] != 5'd0, plen_q[0] != 5'd0} : 8'd0;
    end
    if (st_q == ST_MIX) begin
      okind_q   <= 1'b1;
      ordata_q  <= '0;
      osample_q <= 19'(PULSE_WGT * 19'(psum_q)) + 19'(NOISE_WGT * 19'(nout_q)) +
                   (en_q[4] ? 19'(DMC_WGT * 19'(dmc_q)) : 19'd0);
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'd0, osample_q, ordata_q};
  assign m_axis_tuser  = okind_q;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !s_axis_tready) else $error("input taken mid tick");
  a_div_only_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstat.busy |-> (st_q == ST_WAIT)) else $error("divider busy outside tick");
  a_mix_gives_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MIX) |=> (m_axis_tvalid && m_axis_tuser)) else $error("sample lost");
`endif

endmodule
